/* rtl/mhs_pkg.sv */
`timescale 1ns / 1ps
package mhs_pkg;
  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_LOAD   = 2'd3;
  localparam logic [13:0] PRIME_MOD = 14'd8713;
  // ceil(2^42 / 8713), exact floor division for dividends below 2^28
  localparam logic [28:0] PRIME_RECIP = 29'd504768336;
  localparam logic [13:0] SIG_EMPTY = 14'h3FFF;
  localparam logic CFG_SHINGLE = 1'b0;
  localparam logic CFG_HASHES  = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [13:0] row_index;
    logic [31:0] doc_mask;
    logic [3:0]  hash_select;
    logic [4:0]  doc_select;
    logic [13:0] coef_a;
    logic [13:0] coef_b;
  } cmd_t;
endpackage

/* rtl/minhash_signature_engine.sv */
`timescale 1ns / 1ps
// MinHash signature engine.
// Input is a queue: drive in_* and push; a transfer happens when push is
// high and full is low. Opcodes: update row, read entry, clear, load coefs.
// Results appear only for reads; out_* is valid while empty is low and a
// transfer happens when pop is high.
// A two-entry command queue decouples intake from the execution sequencer.
// Update: the item is taken, then per active hash function: coef read,
// multiply, reciprocal mod 8713, 14-step bit-serial mod shingle_count
// (skipped when shingle_count is 0), table update, with all documents
// compared in parallel. Read: the entry is read and registered. Clear and
// reset: each hash row (NUM_HASH rounded up to a power of two) is emptied
// in turn; no item is executed until the reset clearing pass ends. Load:
// coefs are written as the item is taken. A read is held while an earlier
// result is untaken; other commands proceed. cfg_* writes take effect at
// once; the user must make them only when idle; the block does not check.
module minhash_signature_engine #(
  parameter int NUM_HASH = 16,
  parameter int NUM_DOCS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [13:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_opcode,
  input  logic [13:0] in_row_index,
  input  logic [31:0] in_doc_mask,
  input  logic [3:0]  in_hash_select,
  input  logic [4:0]  in_doc_select,
  input  logic [13:0] in_coef_a,
  input  logic [13:0] in_coef_b,
  output logic        empty,
  input  logic        pop,
  output logic [13:0] out_sig_value,
  output logic        out_is_empty
);
  logic [13:0] shingle_count_r;
  logic [4:0]  hash_count_r;
  mhs_pkg::cmd_t in_cmd, q_cmd;
  logic q_valid, q_take, res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shingle_count_r <= mhs_pkg::PRIME_MOD;
      hash_count_r    <= 5'd16;
    end else if (cfg_we) begin
      if (cfg_index == mhs_pkg::CFG_SHINGLE) shingle_count_r <= cfg_data;
      else hash_count_r <= cfg_data[4:0];
    end
  end

  assign in_cmd = '{opcode: in_opcode, row_index: in_row_index,
    doc_mask: in_doc_mask, hash_select: in_hash_select,
    doc_select: in_doc_select, coef_a: in_coef_a, coef_b: in_coef_b};

  mhs_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_cmd(in_cmd),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take));

  mhs_back #(.NUM_HASH(NUM_HASH), .NUM_DOCS(NUM_DOCS)) u_back (
    .clk(clk), .rst_n(rst_n), .shingle_count(shingle_count_r),
    .hash_count(hash_count_r), .q_valid(q_valid), .q_cmd(q_cmd),
    .q_take(q_take), .res_valid(res_valid), .res_value(out_sig_value),
    .res_take(pop && res_valid));

  assign empty = !res_valid;
  assign out_is_empty = (out_sig_value == mhs_pkg::SIG_EMPTY);
endmodule

/* rtl/mhs_ram.sv */
`timescale 1ns / 1ps
module mhs_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/mhs_front.sv */
`timescale 1ns / 1ps
module mhs_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  mhs_pkg::cmd_t  in_cmd,
  output logic           q_valid,
  output mhs_pkg::cmd_t  q_cmd,
  input  logic           q_take
);
  // two-entry queue
  mhs_pkg::cmd_t ent_r [2];
  logic [1:0] cnt_r;
  logic rd_r, wr_r;
  logic do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = ent_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_r] <= in_cmd;
    end
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (do_push) wr_r <= ~wr_r;
      if (do_pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) do_pop |-> cnt_r != 2'd0)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !do_pop) |=> cnt_r == 2'd2)
    else $error("queue lost entry");
endmodule

/* rtl/mhs_back.sv */
`timescale 1ns / 1ps
module mhs_back #(
  parameter int NUM_HASH = 16,
  parameter int NUM_DOCS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [13:0]   shingle_count,
  input  logic [4:0]    hash_count,
  input  logic          q_valid,
  input  mhs_pkg::cmd_t q_cmd,
  output logic          q_take,
  output logic          res_valid,
  output logic [13:0]   res_value,
  input  logic          res_take
);
  localparam int HW = (NUM_HASH > 1) ? $clog2(NUM_HASH) : 1;
  localparam int DW = (NUM_DOCS > 1) ? $clog2(NUM_DOCS) : 1;
  localparam int HC = HW + 1;
  localparam int ND = (NUM_DOCS < 32) ? NUM_DOCS : 32;

  localparam logic [3:0] S_IDLE = 4'd0, S_CA = 4'd1, S_CB = 4'd2,
    S_MUL = 4'd3, S_MOD = 4'd4, S_MOD2 = 4'd5, S_SRD = 4'd6,
    S_UPD = 4'd7, S_RD = 4'd8, S_RD2 = 4'd9, S_CLR = 4'd10;

  logic [3:0] st_r;
  logic [HC-1:0] h_r, nh_r;
  logic [27:0] prod_r;
  logic [14:0] q_r;
  logic [13:0] v_r;
  logic [4:0]  mcnt_r;
  logic [HW-1:0] cd_r;
  mhs_pkg::cmd_t cmd_r;
  logic rv_r;
  logic [13:0] rval_r;
  logic oor_r;

  logic [27:0] c_rd;
  logic c_we;
  logic [HW-1:0] c_addr;
  logic [13:0] s_rd [NUM_DOCS];
  logic [13:0] s_wd [NUM_DOCS];
  logic [NUM_DOCS-1:0] s_we;
  logic [HW-1:0] s_waddr, s_raddr;
  logic [56:0] qprod;
  logic [27:0] rem_full, sc_shift, v_sub;

  logic [HC-1:0] hc_sat;
  assign hc_sat = ({27'd0, hash_count} > 32'(NUM_HASH)) ? HC'(NUM_HASH) : HC'(hash_count);

  assign c_we   = (st_r == S_IDLE) && q_valid && q_cmd.opcode == mhs_pkg::OP_LOAD
                  && ({28'd0, q_cmd.hash_select} < 32'(NUM_HASH));
  assign c_addr = (st_r == S_IDLE) ? HW'(q_cmd.hash_select) : h_r[HW-1:0];

  mhs_ram #(.WIDTH(28), .DEPTH(1 << HW)) u_coef (
    .clk(clk), .we(c_we), .waddr(HW'(q_cmd.hash_select)),
    .wdata({q_cmd.coef_b, q_cmd.coef_a}), .raddr(c_addr), .rdata(c_rd));

  genvar g;
  generate
    for (g = 0; g < NUM_DOCS; g++) begin : g_col
      mhs_ram #(.WIDTH(14), .DEPTH(1 << HW)) u_sig (
        .clk(clk), .we(s_we[g]), .waddr(s_waddr), .wdata(s_wd[g]),
        .raddr(s_raddr), .rdata(s_rd[g]));
      always_comb begin
        s_we[g] = 1'b0;
        s_wd[g] = v_r;
        if (st_r == S_CLR) begin
          s_we[g] = 1'b1;
          s_wd[g] = mhs_pkg::SIG_EMPTY;
        end else if (st_r == S_UPD && g < ND) begin
          s_we[g] = cmd_r.doc_mask[g] && (v_r < s_rd[g]);
        end
      end
    end
  endgenerate

  assign s_waddr = (st_r == S_CLR) ? cd_r : h_r[HW-1:0];
  assign s_raddr = (st_r == S_RD) ? HW'(cmd_r.hash_select) : h_r[HW-1:0];

  // mod 8713 by reciprocal multiply, then one subtract
  assign qprod    = {29'd0, prod_r} * {28'd0, mhs_pkg::PRIME_RECIP};
  assign rem_full = prod_r - {13'd0, q_r} * {14'd0, mhs_pkg::PRIME_MOD};
  assign sc_shift = {14'd0, shingle_count} << mcnt_r;
  assign v_sub    = {14'd0, v_r} - sc_shift;

  assign q_take = (st_r == S_IDLE) && q_valid
                  && !(q_cmd.opcode == mhs_pkg::OP_READ && rv_r && !res_take);
  assign res_valid = rv_r;
  assign res_value = rval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
    end else if (st_r == S_RD2) begin
      rv_r <= 1'b1;
    end else if (res_take) begin
      rv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      cd_r <= '0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (q_take) begin
            cmd_r <= q_cmd;
            h_r   <= '0;
            nh_r  <= hc_sat;
            case (q_cmd.opcode)
              mhs_pkg::OP_UPDATE: st_r <= (hc_sat == '0) ? S_IDLE : S_CA;
              mhs_pkg::OP_READ: begin
                oor_r <= ({28'd0, q_cmd.hash_select} >= 32'(NUM_HASH))
                         || ({27'd0, q_cmd.doc_select} >= 32'(NUM_DOCS));
                st_r <= S_RD;
              end
              mhs_pkg::OP_CLEAR: begin
                cd_r <= '0;
                st_r <= S_CLR;
              end
              default: st_r <= S_IDLE;
            endcase
          end
        end
        S_CA: st_r <= S_CB;
        S_CB: begin
          prod_r <= c_rd[13:0] * cmd_r.row_index + {14'd0, c_rd[27:14]};
          st_r <= S_MUL;
        end
        S_MUL: begin
          q_r <= qprod[56:42];
          st_r <= S_MOD;
        end
        S_MOD: begin
          v_r <= rem_full[13:0];
          mcnt_r <= 5'd13;
          st_r <= S_MOD2;
        end
        S_MOD2: begin
          // restoring remainder by shingle_count, one bit a cycle
          if (shingle_count == 14'd0) begin
            st_r <= S_SRD;
          end else begin
            if ({14'd0, v_r} >= sc_shift)
              v_r <= v_sub[13:0];
            if (mcnt_r == 5'd0) st_r <= S_SRD;
            else mcnt_r <= mcnt_r - 5'd1;
          end
        end
        S_SRD: st_r <= S_UPD;
        S_UPD: begin
          if (h_r + 1'b1 == nh_r) begin
            st_r <= S_IDLE;
          end else begin
            h_r <= h_r + 1'b1;
            st_r <= S_CA;
          end
        end
        S_RD: st_r <= S_RD2;
        S_RD2: begin
          rval_r <= oor_r ? mhs_pkg::SIG_EMPTY : s_rd[cmd_r.doc_select[DW-1:0]];
          st_r <= S_IDLE;
        end
        S_CLR: begin
          cd_r <= cd_r + 1'b1;
          if (cd_r == {HW{1'b1}}) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RD2) |=> rv_r)
    else $error("read gave no result");
  assert property (@(posedge clk) disable iff (!rst_n)
    (rv_r && !res_take) |=> rv_r)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_UPD) |-> v_r < 14'(mhs_pkg::PRIME_MOD))
    else $error("hash out of range");
endmodule
